>>> rtl/core/rv32i_integer_execute_defines.svh
// ----------------------------------------------------------------------------
// RV32I integer execute - assertion macros
// Shared concurrent assertion forms used across the block.
// ----------------------------------------------------------------------------
`ifndef RV32I_INTEGER_EXECUTE_DEFINES_SVH
`define RV32I_INTEGER_EXECUTE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define RVX_ASSERT_IMPL(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define RVX_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/core/rvx_pkg.sv
// ----------------------------------------------------------------------------
// RV32I integer execute - package
// Opcodes, status codes and the decoded operation beat.
// ----------------------------------------------------------------------------
package rvx_pkg;

	localparam logic [6:0] OPC_OP      = 7'h33;
	localparam logic [6:0] OPC_OPIMM   = 7'h13;
	localparam logic [6:0] OPC_LOAD    = 7'h03;
	localparam logic [6:0] OPC_MISCMEM = 7'h0F;
	localparam logic [6:0] OPC_SYSTEM  = 7'h73;
	localparam logic [6:0] OPC_STORE   = 7'h23;
	localparam logic [6:0] OPC_BRANCH  = 7'h63;
	localparam logic [6:0] OPC_LUI     = 7'h37;
	localparam logic [6:0] OPC_AUIPC   = 7'h17;
	localparam logic [6:0] OPC_JAL     = 7'h6F;
	localparam logic [6:0] OPC_JALR    = 7'h67;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BADOPC  = 2'd1;
	localparam logic [1:0] ST_UNIMPL  = 2'd2;

	typedef enum logic [3:0] {
		ALU_ADD, ALU_SUB, ALU_SLL, ALU_SLT, ALU_SLTU, ALU_XOR,
		ALU_SRL, ALU_SRA, ALU_OR, ALU_AND
	} alu_op_t;

	typedef enum logic [2:0] {
		K_NOP, K_ALU, K_LUI, K_AUIPC, K_JAL, K_JALR, K_BRANCH, K_HOLD
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		alu_op_t     alu_op;
		logic        use_imm;
		logic [2:0]  f3;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [4:0]  rd;
		logic [31:0] imm;
		logic [1:0]  status;
	} dec_t;

endpackage

>>> rtl/core/rvx_decode.sv
// ----------------------------------------------------------------------------
// RV32I integer execute - front end
// Classifies instruction words into decoded beats and queues them.
// ----------------------------------------------------------------------------
module rvx_decode import rvx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] instruction,
	output logic        dec_valid,
	input  logic        dec_take,
	output dec_t        dec
);

	dec_t       q_mem [2];
	logic [1:0] cnt_q;
	logic       wp_q;
	logic       rp_q;
	dec_t       d;
	logic [6:0] opc;
	logic [2:0] f3;
	logic [6:0] f7;
	logic       f7ok;
	logic       do_push;
	logic       do_pop;

	assign opc  = instruction[6:0];
	assign f3   = instruction[14:12];
	assign f7   = instruction[31:25];

	always_comb begin
		d         = '0;
		d.kind    = K_NOP;
		d.alu_op  = ALU_ADD;
		d.f3      = f3;
		d.rs1     = instruction[19:15];
		d.rs2     = instruction[24:20];
		d.rd      = instruction[11:7];
		d.status  = ST_OK;
		d.use_imm = (opc == OPC_OPIMM);
		f7ok      = (opc == OPC_OPIMM) || (f7 == F7_BASE);
		d.imm     = {{20{instruction[31]}}, instruction[31:20]};
		unique case (opc)
			OPC_OP, OPC_OPIMM: begin
				d.kind = K_ALU;
				case (f3)
					3'd0: begin
						if (opc == OPC_OPIMM || f7 == F7_BASE) d.alu_op = ALU_ADD;
						else if (f7 == F7_ALT) d.alu_op = ALU_SUB;
						else d.status = ST_UNIMPL;
					end
					3'd1: begin
						d.alu_op = ALU_SLL;
						if (f7 != F7_BASE) d.status = ST_UNIMPL;
					end
					3'd5: begin
						if (f7 == F7_BASE) d.alu_op = ALU_SRL;
						else if (f7 == F7_ALT) d.alu_op = ALU_SRA;
						else d.status = ST_UNIMPL;
					end
					default: begin
						case (f3)
							3'd2: d.alu_op = ALU_SLT;
							3'd3: d.alu_op = ALU_SLTU;
							3'd4: d.alu_op = ALU_XOR;
							3'd6: d.alu_op = ALU_OR;
							default: d.alu_op = ALU_AND;
						endcase
						if (!f7ok) d.status = ST_UNIMPL;
					end
				endcase
				if (d.status != ST_OK) d.kind = K_NOP;
			end
			OPC_LOAD, OPC_STORE: d.status = ST_UNIMPL;
			OPC_MISCMEM: if (f3 != 3'd0) d.status = ST_UNIMPL;
			OPC_SYSTEM: begin
				if (f3 != 3'd0 || instruction[31:21] != 11'd0) d.status = ST_UNIMPL;
			end
			OPC_LUI: begin
				d.kind = K_LUI;
				d.imm  = {instruction[31:12], 12'd0};
			end
			OPC_AUIPC: begin
				d.kind = K_AUIPC;
				d.imm  = {instruction[31:12], 12'd0};
			end
			OPC_JAL: begin
				d.kind = K_JAL;
				d.imm  = {{12{instruction[31]}}, instruction[19:12], instruction[20],
					instruction[30:21], 1'b0};
			end
			OPC_JALR: begin
				if (f3 != 3'd0) d.status = ST_UNIMPL;
				else d.kind = K_JALR;
			end
			OPC_BRANCH: begin
				d.imm = {{20{instruction[31]}}, instruction[7], instruction[30:25],
					instruction[11:8], 1'b0};
				if (f3 == 3'd2 || f3 == 3'd3) d.status = ST_UNIMPL;
				else d.kind = K_BRANCH;
			end
			default: begin
				d.kind   = K_HOLD;
				d.status = ST_BADOPC;
			end
		endcase
	end

	assign full      = cnt_q[1];
	assign dec_valid = (cnt_q != 2'd0);
	assign dec       = q_mem[rp_q];
	assign do_push   = push && !full;
	assign do_pop    = dec_take && dec_valid;

	always_ff @(posedge clk) begin
		if (do_push) q_mem[wp_q] <= d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (do_push) wp_q <= !wp_q;
			if (do_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

>>> rtl/core/rvx_execute.sv
// ----------------------------------------------------------------------------
// RV32I integer execute - back end
// Reads registers, runs the ALU and branch unit, updates pc and results.
// ----------------------------------------------------------------------------
`include "rv32i_integer_execute_defines.svh"
module rvx_execute import rvx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        dec_valid,
	output logic        dec_take,
	input  dec_t        dec,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] next_pc,
	output logic        reg_write,
	output logic [4:0]  reg_index,
	output logic [31:0] reg_value,
	output logic [1:0]  status
);

	logic [31:0] rf_q [32];
	logic [31:0] pc_q;
	logic        ovalid_q;
	logic [31:0] a;
	logic [31:0] b;
	logic [31:0] opb;
	logic [31:0] alu_res;
	logic [31:0] val;
	logic [31:0] nxt;
	logic        wr;
	logic        take;
	logic        fire;

	assign a   = (dec.rs1 == 5'd0) ? 32'd0 : rf_q[dec.rs1];
	assign b   = (dec.rs2 == 5'd0) ? 32'd0 : rf_q[dec.rs2];
	assign opb = dec.use_imm ? dec.imm : b;

	always_comb begin
		unique case (dec.alu_op)
			ALU_ADD:  alu_res = a + opb;
			ALU_SUB:  alu_res = a - opb;
			ALU_SLL:  alu_res = a << opb[4:0];
			ALU_SLT:  alu_res = {31'd0, $signed(a) < $signed(opb)};
			ALU_SLTU: alu_res = {31'd0, a < opb};
			ALU_XOR:  alu_res = a ^ opb;
			ALU_SRL:  alu_res = a >> opb[4:0];
			ALU_SRA:  alu_res = $unsigned($signed(a) >>> opb[4:0]);
			ALU_OR:   alu_res = a | opb;
			default:  alu_res = a & opb;
		endcase
	end

	always_comb begin
		case (dec.f3)
			3'd0: take = (a == b);
			3'd1: take = (a != b);
			3'd4: take = $signed(a) < $signed(b);
			3'd5: take = !($signed(a) < $signed(b));
			3'd6: take = a < b;
			default: take = a >= b;
		endcase
		nxt = pc_q + 32'd4;
		val = 32'd0;
		wr  = 1'b0;
		unique case (dec.kind)
			K_ALU: begin
				val = alu_res;
				wr  = 1'b1;
			end
			K_LUI: begin
				val = dec.imm;
				wr  = 1'b1;
			end
			K_AUIPC: begin
				val = pc_q + dec.imm;
				wr  = 1'b1;
			end
			K_JAL: begin
				nxt = pc_q + dec.imm;
				val = pc_q + 32'd4;
				wr  = 1'b1;
			end
			K_JALR: begin
				nxt = (a + dec.imm) & ~32'd1;
				val = pc_q + 32'd4;
				wr  = 1'b1;
			end
			K_BRANCH: if (take) nxt = pc_q + dec.imm;
			K_HOLD: nxt = pc_q;
			default: ;
		endcase
		if (dec.rd == 5'd0) wr = 1'b0;
		if (!wr) val = 32'd0;
	end

	assign empty    = !ovalid_q;
	assign dec_take = !ovalid_q || pop;
	assign fire     = dec_valid && dec_take;

	always_ff @(posedge clk) begin
		if (fire) begin
			next_pc   <= nxt;
			reg_write <= wr;
			reg_index <= wr ? dec.rd : 5'd0;
			reg_value <= val;
			status    <= dec.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= 32'd0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < 32; i++) rf_q[i] <= 32'd0;
		end else begin
			if (fire && wr) rf_q[dec.rd] <= val;
			if (fire) pc_q <= nxt;
			if (fire) ovalid_q <= 1'b1;
			else if (pop) ovalid_q <= 1'b0;
		end
	end

	`RVX_ASSERT_IMPL(a_write_nonzero, clk, arst_n, !empty && reg_write, reg_index != 5'd0)
	`RVX_ASSERT_IMPL(a_nowrite_zero, clk, arst_n, !empty && !reg_write,
		reg_value == 32'd0 && reg_index == 5'd0)
	`RVX_ASSERT_NEXT(a_pc_tracks, clk, arst_n, fire, pc_q == next_pc)
	`RVX_ASSERT_IMPL(a_hold_pc, clk, arst_n, !empty && status == ST_BADOPC, !reg_write)

endmodule

>>> rtl/core/rv32i_integer_execute.sv
// ----------------------------------------------------------------------------
// RV32I integer execute - top level
// Decode fills a two-entry queue; execute takes one per cycle if not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive instruction with push; the word is taken on a clock
//   edge where push is high and full is low.
//   Result channel: while empty is low, next_pc, reg_write, reg_index,
//   reg_value and status show the oldest result; pop takes it.
//   Path: the word is first written into the decode queue and is executed
//   into the output register when the back end takes it from that queue.
//   Throughput: one instruction per cycle while results are popped, set by the
//   two register-file reads, the single write and the pc update in execute.
//   Reset: arst_n low clears pc to zero, the register file to zero and both
//   queues to empty.
//   Stall: with pop low the output register holds; the decode queue then
//   fills and full rises after two further words.
// ----------------------------------------------------------------------------
module rv32i_integer_execute import rvx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] instruction,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] next_pc,
	output logic        reg_write,
	output logic [4:0]  reg_index,
	output logic [31:0] reg_value,
	output logic [1:0]  status
);

	logic dec_valid;
	logic dec_take;
	dec_t dec;

	rvx_decode u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.instruction(instruction), .dec_valid(dec_valid),
		.dec_take(dec_take), .dec(dec)
	);

	rvx_execute u_execute (
		.clk(clk), .arst_n(arst_n), .dec_valid(dec_valid), .dec_take(dec_take),
		.dec(dec), .empty(empty), .pop(pop), .next_pc(next_pc),
		.reg_write(reg_write), .reg_index(reg_index), .reg_value(reg_value),
		.status(status)
	);

endmodule

>>> sim/rv32i_integer_execute_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32I integer execute - result checker
// Watches the instruction and result queues, runs its own copy of the
// register file and pc on every accepted word, and compares each popped
// result field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module rv32i_integer_execute_checker import rvx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [31:0] instruction,
	input  logic        empty,
	input  logic        pop,
	input  logic [31:0] next_pc,
	input  logic        reg_write,
	input  logic [4:0]  reg_index,
	input  logic [31:0] reg_value,
	input  logic [1:0]  status,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [31:0] npc;
		logic        wr;
		logic [4:0]  idx;
		logic [31:0] val;
		logic [1:0]  st;
	} exec_result_t;

	logic [31:0] gpr [32];
	logic [31:0] pc;
	exec_result_t expected_q[$];

	assign pending = expected_q.size();

	function automatic logic [31:0] alu_result(input logic [2:0] f3, input logic [6:0] f7,
			input logic [31:0] a, input logic [31:0] b, input logic is_imm,
			output logic ok);
		ok = 1'b1;
		alu_result = '0;
		case (f3)
			3'd0: if (is_imm || f7 == F7_BASE) alu_result = a + b;
				else if (f7 == F7_ALT) alu_result = a - b;
				else ok = 1'b0;
			3'd1: if (f7 == F7_BASE) alu_result = a << b[4:0]; else ok = 1'b0;
			3'd2: if (is_imm || f7 == F7_BASE) alu_result = {31'd0, $signed(a) < $signed(b)};
				else ok = 1'b0;
			3'd3: if (is_imm || f7 == F7_BASE) alu_result = {31'd0, a < b}; else ok = 1'b0;
			3'd4: if (is_imm || f7 == F7_BASE) alu_result = a ^ b; else ok = 1'b0;
			3'd5: if (f7 == F7_BASE) alu_result = a >> b[4:0];
				else if (f7 == F7_ALT) alu_result = $unsigned($signed(a) >>> b[4:0]);
				else ok = 1'b0;
			3'd6: if (is_imm || f7 == F7_BASE) alu_result = a | b; else ok = 1'b0;
			default: if (is_imm || f7 == F7_BASE) alu_result = a & b; else ok = 1'b0;
		endcase
	endfunction

	function automatic exec_result_t execute_word(input logic [31:0] ins);
		exec_result_t r;
		logic [4:0]  rd;
		logic [2:0]  f3;
		logic [31:0] a, b, imm_i, imm_b, imm_j, val;
		logic        ok, wr, take;
		rd = ins[11:7];
		f3 = ins[14:12];
		a = gpr[ins[19:15]];
		b = gpr[ins[24:20]];
		imm_i = {{20{ins[31]}}, ins[31:20]};
		imm_b = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
		imm_j = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
		r.npc = pc + 32'd4;
		r.st = ST_OK;
		val = '0;
		wr = 1'b0;
		take = 1'b0;
		case (ins[6:0])
			OPC_OP: begin
				val = alu_result(f3, ins[31:25], a, b, 1'b0, ok);
				if (ok) wr = 1'b1; else r.st = ST_UNIMPL;
			end
			OPC_OPIMM: begin
				val = alu_result(f3, ins[31:25], a, imm_i, 1'b1, ok);
				if (ok) wr = 1'b1; else r.st = ST_UNIMPL;
			end
			OPC_LOAD, OPC_STORE: r.st = ST_UNIMPL;
			OPC_MISCMEM: if (f3 != 3'd0) r.st = ST_UNIMPL;
			OPC_SYSTEM: if (f3 != 3'd0 || ins[31:20] > 12'd1) r.st = ST_UNIMPL;
			OPC_LUI: begin
				val = {ins[31:12], 12'd0};
				wr = 1'b1;
			end
			OPC_AUIPC: begin
				val = pc + {ins[31:12], 12'd0};
				wr = 1'b1;
			end
			OPC_JAL: begin
				r.npc = pc + imm_j;
				val = pc + 32'd4;
				wr = 1'b1;
			end
			OPC_JALR: if (f3 != 3'd0) r.st = ST_UNIMPL;
				else begin
					r.npc = (a + imm_i) & ~32'd1;
					val = pc + 32'd4;
					wr = 1'b1;
				end
			OPC_BRANCH: begin
				case (f3)
					3'd0: take = a == b;
					3'd1: take = a != b;
					3'd4: take = $signed(a) < $signed(b);
					3'd5: take = $signed(a) >= $signed(b);
					3'd6: take = a < b;
					3'd7: take = a >= b;
					default: r.st = ST_UNIMPL;
				endcase
				if (take) r.npc = pc + imm_b;
			end
			default: begin
				r.st = ST_BADOPC;
				r.npc = pc;
			end
		endcase
		if (!wr || rd == 5'd0) begin
			r.wr = 1'b0;
			r.idx = '0;
			r.val = '0;
		end else begin
			r.wr = 1'b1;
			r.idx = rd;
			r.val = val;
			gpr[rd] = val;
		end
		pc = r.npc;
		return r;
	endfunction

	always @(posedge clk) begin
		exec_result_t exp_r, got;
		if (!arst_n) begin
			fail_count = 0;
			pc = '0;
			for (int i = 0; i < 32; i++) gpr[i] = '0;
		end else begin
			if (push && !full) expected_q.push_back(execute_word(instruction));
			if (pop && !empty) begin
				got = '{next_pc, reg_write, reg_index, reg_value, status};
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected result beat %h", got);
				end else begin
					exp_r = expected_q.pop_front();
					if (got !== exp_r) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp pc=%h wr=%b rd=%0d val=%h st=%0d",
								exp_r.npc, exp_r.wr, exp_r.idx, exp_r.val, exp_r.st,
								" got pc=%h wr=%b rd=%0d val=%h st=%0d",
								got.npc, got.wr, got.idx, got.val, got.st);
					end
				end
			end
		end
	end

endmodule

>>> sim/tb_rv32i_integer_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32I integer execute - testbench top
// Feeds directed and random RV32I words with random gaps and result stalls;
// the checker predicts and compares, and the top gives the verdict.
// ----------------------------------------------------------------------------
module tb_rv32i_integer_execute;
	import rvx_pkg::*;

	localparam int IDLE_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	logic [31:0] instruction = '0;
	logic        full, empty, reg_write;
	logic [31:0] next_pc, reg_value;
	logic [4:0]  reg_index;
	logic [1:0]  status;
	int          fail_count, pending, idle_cycles;
	int          pop_gap = 0;
	logic        words_done = 1'b0;

	always #10 clk = ~clk;

	rv32i_integer_execute dut (.*);
	rv32i_integer_execute_checker chk (.*);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [31:0] random_word();
		logic [6:0] opc_set [11];
		logic [31:0] w;
		int r;
		opc_set = '{OPC_OP, OPC_OPIMM, OPC_LOAD, OPC_MISCMEM, OPC_SYSTEM, OPC_STORE,
			OPC_BRANCH, OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR};
		w = $urandom();
		r = $urandom_range(0, 99);
		if (r < 5) return w;
		w[6:0] = opc_set[$urandom_range(0, 10)];
		if (r < 60) w[6:0] = ($urandom_range(0, 1) != 0) ? OPC_OP : OPC_OPIMM;
		if (r < 85 && (w[6:0] == OPC_OP || w[6:0] == OPC_OPIMM))
			w[31:25] = ($urandom_range(0, 3) == 0) ? F7_ALT : F7_BASE;
		if (w[6:0] == OPC_OPIMM && w[14:12] == 3'd0 && $urandom_range(0, 3) == 0)
			w[19:15] = 5'd0;
		if (w[6:0] == OPC_JALR && r < 90) w[14:12] = 3'd0;
		if (w[6:0] == OPC_SYSTEM && r < 90)
			w[31:12] = {11'd0, 1'($urandom_range(0, 1)), 8'd0};
		if (w[19:15] != 5'd0 && $urandom_range(0, 3) == 0) w[24:20] = w[19:15];
		return w;
	endfunction

	task automatic send_word(input logic [31:0] w);
		int g;
		g = gap_len();
		push <= 1'b1;
		instruction <= w;
		do @(posedge clk); while (full);
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	initial begin
		logic [31:0] directed [$];
		directed = '{
			32'h0000_0013, 32'hFFF0_0093, 32'h7FF0_8113, 32'h8000_01B7, 32'h0000_1217,
			32'h4020_82B3, 32'h0020_8333, 32'h0010_93B3, 32'h01F1_5413, 32'h41F1_5493,
			32'h0011_2533, 32'h0011_35B3, 32'h0020_C633, 32'h0020_E6B3, 32'h0020_F733,
			32'h0020_8463, 32'h0020_9463, 32'hFE20_CEE3, 32'h0020_D463, 32'h0020_E463,
			32'h0020_F463, 32'h0080_00EF, 32'hFFC0_8067, 32'h0000_000F, 32'h0000_0073,
			32'h0010_0073, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_2003, 32'h0220_8033};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) send_word(directed[i]);
		repeat (2000) send_word(random_word());
		push <= 1'b0;
		words_done <= 1'b1;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
			pop_gap = 0;
		end else if (pop_gap > 0) begin
			pop <= 1'b0;
			pop_gap--;
		end else if ($urandom_range(0, 99) < 25) begin
			pop <= 1'b0;
			pop_gap = gap_len();
		end else pop <= 1'b1;
	end

	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_rv32i_integer_execute NOT OK");
				$finish;
			end
			if (words_done && pending == 0) begin
				repeat (10) @(posedge clk);
				if (fail_count == 0) $display("tb_rv32i_integer_execute OK");
				else $display("tb_rv32i_integer_execute NOT OK");
				$finish;
			end
		end
	end

endmodule

>>> rv32i_integer_execute.f
+incdir+rtl/core
rtl/core/rvx_pkg.sv
rtl/core/rvx_decode.sv
rtl/core/rvx_execute.sv
rtl/core/rv32i_integer_execute.sv
sim/rv32i_integer_execute_checker.sv
sim/tb_rv32i_integer_execute.sv
